>>> hdl/stpf_pkg.sv
// Shared types and constants of the spectrum top-peak finder.
package stpf_pkg;

    localparam int LEVEL_W    = 8;
    localparam int BIN_IDX_W  = 10;
    localparam int RANK_W     = 3;
    localparam int CNT_CFG_W  = 4;
    localparam int HW_CFG_W   = 4;
    localparam int LEN_CFG_W  = 11;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = {1'b1, {(LEVEL_W-1){1'b0}}};

    localparam logic [CNT_CFG_W-1:0] RST_PEAK_COUNT      = 4'd1;
    localparam logic [HW_CFG_W-1:0]  RST_PEAK_WIDTH      = 4'd0;
    localparam logic [LEN_CFG_W-1:0] RST_SPECTRUM_LENGTH = 11'd1024;

    // Register index, taken from paddr[3:2].
    localparam logic [1:0] REG_PEAK_COUNT      = 2'd0;
    localparam logic [1:0] REG_PEAK_WIDTH      = 2'd1;
    localparam logic [1:0] REG_SPECTRUM_LENGTH = 2'd2;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic [BIN_IDX_W-1:0]      bin_index;
        logic signed [LEVEL_W-1:0] bin_value;
    } in_item_t;

    typedef struct packed {
        logic [RANK_W-1:0]         peak_rank;
        logic [BIN_IDX_W-1:0]      peak_bin;
        logic signed [LEVEL_W-1:0] peak_level;
        logic                      last_peak;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_en;
        logic scan_rd;
        logic first_pass;
        logic clr_max;
        logic emit;
        logic last;
        logic sup_wr;
    } dp_cmd_t;

endpackage

>>> hdl/stpf_datapath.sv
// Datapath of the peak finder: bin store, suppression mask, running maximum and result register.
module stpf_datapath #(
    parameter int BIN_DEPTH = 1024,
    parameter int MAX_PEAKS = 8
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  stpf_pkg::dp_cmd_t                                 cmd,
    input  stpf_pkg::in_item_t                                item,
    input  logic [$clog2(BIN_DEPTH)-1:0]                      scan_addr,
    input  logic [$clog2(BIN_DEPTH)-1:0]                      sup_addr,
    input  logic [$clog2(MAX_PEAKS+1)-1:0]                    rank,
    output logic [$clog2(BIN_DEPTH)-1:0]                      peak_index,
    output logic                                              strobe,
    output stpf_pkg::out_item_t                               result
);
    import stpf_pkg::*;

    localparam int ADDR_W = $clog2(BIN_DEPTH);

    logic signed [LEVEL_W-1:0] spec_mem [BIN_DEPTH];
    logic                      mask_mem [BIN_DEPTH];

    logic signed [LEVEL_W-1:0] rd_level_reg;
    logic                      rd_masked_reg;
    logic                      rd_valid_reg;
    logic [ADDR_W-1:0]         rd_index_reg;
    logic signed [LEVEL_W-1:0] max_reg;
    logic [ADDR_W-1:0]         max_index_reg;
    logic                      strobe_reg;
    out_item_t                 result_reg;
    logic                      load_in_range;
    logic                      mask_we;
    logic                      mask_wdata;
    logic [ADDR_W-1:0]         mask_waddr;

    assign load_in_range = (32'(item.bin_index) < 32'(BIN_DEPTH));

    // The first pass of a search clears the mask behind the scan; the suppression step of every pass sets it.
    assign mask_we    = (cmd.scan_rd && cmd.first_pass) || cmd.sup_wr;
    assign mask_wdata = cmd.sup_wr;
    assign mask_waddr = cmd.sup_wr ? sup_addr : scan_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.load_en && load_in_range)
        begin
            spec_mem[ADDR_W'(item.bin_index)] <= item.bin_value;
        end
        if (mask_we)
        begin
            mask_mem[mask_waddr] <= mask_wdata;
        end
        rd_level_reg  <= spec_mem[scan_addr];
        rd_masked_reg <= cmd.first_pass ? 1'b0 : mask_mem[scan_addr];
        rd_index_reg  <= scan_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            max_reg       <= LEVEL_FLOOR;
            max_index_reg <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_rd;
            strobe_reg   <= cmd.emit;
            if (cmd.clr_max)
            begin
                max_reg       <= LEVEL_FLOOR;
                max_index_reg <= '0;
            end
            else if (rd_valid_reg && !rd_masked_reg && (rd_level_reg > max_reg))
            begin
                max_reg       <= rd_level_reg;
                max_index_reg <= rd_index_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.peak_rank  <= RANK_W'(rank);
            result_reg.peak_bin   <= BIN_IDX_W'(max_index_reg);
            result_reg.peak_level <= max_reg;
            result_reg.last_peak  <= cmd.last;
        end
    end

    assign peak_index = max_index_reg;
    assign strobe     = strobe_reg;
    assign result     = result_reg;

endmodule

>>> hdl/stpf_ctrl.sv
// Controller of the peak finder: search sequencing, scan and suppression address counters.
module stpf_ctrl #(
    parameter int BIN_DEPTH      = 1024,
    parameter int MAX_PEAKS      = 8,
    parameter int MAX_HALF_WIDTH = 15
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  stpf_pkg::op_t                          op,
    input  logic [stpf_pkg::CNT_CFG_W-1:0]         cfg_count,
    input  logic [stpf_pkg::HW_CFG_W-1:0]          cfg_width,
    input  logic [stpf_pkg::LEN_CFG_W-1:0]         cfg_len,
    input  logic [$clog2(BIN_DEPTH)-1:0]           peak_index,
    output logic                                   busy,
    output stpf_pkg::dp_cmd_t                      cmd,
    output logic [$clog2(BIN_DEPTH)-1:0]           scan_addr,
    output logic [$clog2(BIN_DEPTH)-1:0]           sup_addr,
    output logic [$clog2(MAX_PEAKS+1)-1:0]         rank
);
    import stpf_pkg::*;

    localparam int ADDR_W = $clog2(BIN_DEPTH);
    localparam int LEN_W  = $clog2(BIN_DEPTH + 1);
    localparam int PASS_W = $clog2(MAX_PEAKS + 1);
    localparam int HW_W   = (MAX_HALF_WIDTH > 0) ? $clog2(MAX_HALF_WIDTH + 1) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_SCAN,
        S_WAIT,
        S_REPORT,
        S_SUPP
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PASS_W-1:0] pass_reg;
    logic [ADDR_W-1:0] sup_addr_reg;
    logic [ADDR_W-1:0] sup_hi_reg;

    logic [PASS_W-1:0] count_sat;
    logic [HW_W-1:0]   width_sat;
    logic [LEN_W-1:0]  len_sat;
    logic [LEN_W-1:0]  len_m1;
    logic              last_pass;
    logic [31:0]       hi_full;
    logic [ADDR_W-1:0] lo_addr;
    logic [ADDR_W-1:0] hi_addr;

    assign count_sat = (32'(cfg_count) > 32'(MAX_PEAKS)) ? PASS_W'(MAX_PEAKS)
                                                         : PASS_W'(cfg_count);
    assign width_sat = (32'(cfg_width) > 32'(MAX_HALF_WIDTH)) ? HW_W'(MAX_HALF_WIDTH)
                                                              : HW_W'(cfg_width);
    assign len_sat   = (32'(cfg_len) > 32'(BIN_DEPTH)) ? LEN_W'(BIN_DEPTH)
                                                       : LEN_W'(cfg_len);
    assign len_m1    = len_sat - LEN_W'(1);
    assign last_pass = (pass_reg == (count_sat - PASS_W'(1)));

    // Suppressed region around the peak, clipped to the first and the last searched bin.
    assign hi_full = 32'(peak_index) + 32'(width_sat);
    assign lo_addr = (32'(peak_index) < 32'(width_sat)) ? '0
                   : ADDR_W'(32'(peak_index) - 32'(width_sat));
    assign hi_addr = (hi_full > 32'(len_m1)) ? ADDR_W'(len_m1) : ADDR_W'(hi_full);

    always_comb
    begin
        cmd            = '0;
        cmd.load_en    = (state_reg == S_IDLE) && start && (op == OP_LOAD);
        cmd.scan_rd    = (state_reg == S_SCAN);
        cmd.first_pass = (pass_reg == '0);
        cmd.clr_max    = (state_reg == S_PASS);
        cmd.emit       = (state_reg == S_REPORT);
        cmd.last       = last_pass;
        cmd.sup_wr     = (state_reg == S_SUPP);
    end

    assign busy      = (state_reg != S_IDLE);
    assign scan_addr = addr_reg;
    assign sup_addr  = sup_addr_reg;
    assign rank      = pass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            addr_reg     <= '0;
            pass_reg     <= '0;
            sup_addr_reg <= '0;
            sup_hi_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start && (op == OP_SEARCH) && (count_sat != '0))
                    begin
                        pass_reg  <= '0;
                        state_reg <= S_PASS;
                    end
                end
                S_PASS:
                begin
                    addr_reg  <= '0;
                    state_reg <= (len_sat == '0) ? S_REPORT : S_SCAN;
                end
                S_SCAN:
                begin
                    if (LEN_W'(addr_reg) == len_m1)
                    begin
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + ADDR_W'(1);
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_REPORT;
                end
                S_REPORT:
                begin
                    if (len_sat != '0)
                    begin
                        sup_addr_reg <= lo_addr;
                        sup_hi_reg   <= hi_addr;
                        state_reg    <= S_SUPP;
                    end
                    else if (last_pass)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        pass_reg  <= pass_reg + PASS_W'(1);
                        state_reg <= S_PASS;
                    end
                end
                S_SUPP:
                begin
                    if (sup_addr_reg == sup_hi_reg)
                    begin
                        if (last_pass)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            pass_reg  <= pass_reg + PASS_W'(1);
                            state_reg <= S_PASS;
                        end
                    end
                    else
                    begin
                        sup_addr_reg <= sup_addr_reg + ADDR_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/spectrum_top_peak_finder_top.sv
// Top level of the spectrum top-peak finder: configuration registers, controller and datapath.
//
// Input beats use a start/busy command handshake: a beat is taken at a rising edge with start
// high and busy low. A load beat (op = load) writes one signed dB level into the bin store at
// bin_index; busy stays low, so bins can be streamed in back to back.
// A search beat (op = search) raises busy for the whole search. Each of the peak_count passes
// (capped at MAX_PEAKS) runs a setup state, a scan of spectrum_length bins (one bin read from
// the single read port of the bin store per cycle), a wait state to finish the compare pipeline,
// a report state and then a suppression step over the hi - lo + 1 bins of the suppressed region,
// at most 2*peak_width + 1; with a zero spectrum length the scan and the suppression are skipped.
// Each peak appears on result marked by strobe, high for a single cycle, in the cycle after its
// report state; the receiver cannot stall it, so it must take every strobed beat. last_peak
// marks the final beat of a search. A search with a peak count of zero returns no beat.
// Reset clears the controller and sets the registers to their defaults; the bin store is not
// cleared, and the suppression mask is rebuilt by the first pass of every search.
// Registers must be written via the APB port only while idle; the block does not enforce it.
module spectrum_top_peak_finder_top #(
    parameter int BIN_DEPTH      = 1024,
    parameter int MAX_PEAKS      = 8,
    parameter int MAX_HALF_WIDTH = 15
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  stpf_pkg::in_item_t                   item,
    output logic                                 strobe,
    output stpf_pkg::out_item_t                  result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [stpf_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [stpf_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [stpf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import stpf_pkg::*;

    localparam int ADDR_W = $clog2(BIN_DEPTH);
    localparam int PASS_W = $clog2(MAX_PEAKS + 1);

    logic [CNT_CFG_W-1:0] peak_count_reg;
    logic [HW_CFG_W-1:0]  peak_width_reg;
    logic [LEN_CFG_W-1:0] spectrum_length_reg;
    logic                 cfg_wr;

    dp_cmd_t              cmd;
    logic [ADDR_W-1:0]    scan_addr;
    logic [ADDR_W-1:0]    sup_addr;
    logic [ADDR_W-1:0]    peak_index;
    logic [PASS_W-1:0]    rank;

    // The APB port has no wait states; a write lands at the end of the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_count_reg      <= RST_PEAK_COUNT;
            peak_width_reg      <= RST_PEAK_WIDTH;
            spectrum_length_reg <= RST_SPECTRUM_LENGTH;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_PEAK_COUNT:      peak_count_reg      <= pwdata[CNT_CFG_W-1:0];
                REG_PEAK_WIDTH:      peak_width_reg      <= pwdata[HW_CFG_W-1:0];
                REG_SPECTRUM_LENGTH: spectrum_length_reg <= pwdata[LEN_CFG_W-1:0];
                default:             ;
            endcase
        end
    end

    // Read data is plain decode of the register address; unmapped addresses read as zero.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_PEAK_COUNT:      prdata = APB_DATA_W'(peak_count_reg);
            REG_PEAK_WIDTH:      prdata = APB_DATA_W'(peak_width_reg);
            REG_SPECTRUM_LENGTH: prdata = APB_DATA_W'(spectrum_length_reg);
            default:             prdata = '0;
        endcase
    end

    stpf_ctrl #(
        .BIN_DEPTH      (BIN_DEPTH),
        .MAX_PEAKS      (MAX_PEAKS),
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (item.op),
        .cfg_count  (peak_count_reg),
        .cfg_width  (peak_width_reg),
        .cfg_len    (spectrum_length_reg),
        .peak_index (peak_index),
        .busy       (busy),
        .cmd        (cmd),
        .scan_addr  (scan_addr),
        .sup_addr   (sup_addr),
        .rank       (rank)
    );

    stpf_datapath #(
        .BIN_DEPTH (BIN_DEPTH),
        .MAX_PEAKS (MAX_PEAKS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .item       (item),
        .scan_addr  (scan_addr),
        .sup_addr   (sup_addr),
        .rank       (rank),
        .peak_index (peak_index),
        .strobe     (strobe),
        .result     (result)
    );

    // A result beat only follows a report cycle, which always belongs to a running search.
    assert property (@(posedge clk) disable iff (!rst_n) strobe |-> $past(busy))
        else $error("result beat without a running search");

    // Reports of one search are separated by at least a setup state, so beats never touch.
    assert property (@(posedge clk) disable iff (!rst_n) strobe |=> !strobe)
        else $error("two result beats in adjacent cycles");

    // A load beat never starts a search.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.op == OP_LOAD) |=> !busy)
        else $error("load beat made the block busy");

    // A beat that is not the last of its search leaves the search running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last_peak) |-> busy)
        else $error("search ended before its last peak");

endmodule
